FILE: rtl/core/trhb_pkg.sv
package trhb_pkg;

  localparam int NUM_CHANNELS = 8;
  localparam int TIME_BITS    = 32;
  localparam int CH_W         = $clog2(NUM_CHANNELS);
  localparam int CNT_W        = $clog2(NUM_CHANNELS + 1);

  // input operations
  localparam logic [2:0] OP_TICK   = 3'd0;
  localparam logic [2:0] OP_CLAIM  = 3'd1;
  localparam logic [2:0] OP_ARM    = 3'd2;
  localparam logic [2:0] OP_HB     = 3'd3;
  localparam logic [2:0] OP_RESULT = 3'd4;

  // result kinds
  localparam logic [2:0] K_CLAIMED = 3'd0;
  localparam logic [2:0] K_ARM_ACK = 3'd1;
  localparam logic [2:0] K_HBEAT   = 3'd2;
  localparam logic [2:0] K_FIRE    = 3'd3;
  localparam logic [2:0] K_RETRY   = 3'd4;
  localparam logic [2:0] K_SUCCESS = 3'd5;
  localparam logic [2:0] K_FAILED  = 3'd6;
  localparam logic [2:0] K_CLOSED  = 3'd7;

  // channel states
  localparam logic [2:0] CS_UNUSED = 3'd0;
  localparam logic [2:0] CS_IDLE   = 3'd1;
  localparam logic [2:0] CS_ARMED  = 3'd2;
  localparam logic [2:0] CS_WAIT   = 3'd3;
  localparam logic [2:0] CS_RESULT = 3'd4;

  // register indexes
  localparam logic [2:0] R_ACTIVE = 3'd0;
  localparam logic [2:0] R_HB_INT = 3'd1;
  localparam logic [2:0] R_REPLY  = 3'd2;
  localparam logic [2:0] R_RETRY  = 3'd3;
  localparam logic [2:0] R_LIMIT  = 3'd4;
  localparam logic [2:0] R_DELAY  = 3'd5;

  typedef struct packed {
    logic        armed;
    logic [3:0]  claimed;
    logic [63:0] plate;
    logic [31:0] tag;
    logic [7:0]  client;
    logic [2:0]  channel;
    logic [2:0]  kind;
  } res_t;

endpackage

FILE: rtl/core/trigger_retry_heartbeat_supervisor_core.sv
// camera channel supervisor
// input stream s_*: one transfer per event (tick, claim, arm, heartbeat reply,
// recognition result); output stream m_*: action reports, tlast on the final
// report caused by one input transfer. an APB port holds the six settings.
// one sequencer drives a shared subtract/compare unit over the channel table,
// one channel entry per cycle unless a stalled report holds it. a tick walks
// the n present channels, after a release pass over them when a dead client
// is released first; a claim walks the k claimed channels; arm, reply and
// result are decoded directly. s_tready is high only while the sequencer is
// idle. reports pass a hold register and an output register, so a stalled
// receiver holds the sequencer only when both are full; then no table entry
// changes until a transfer frees a place. reset clears the table, the time
// counter and the settings to their defaults; no report is then pending.
module trigger_retry_heartbeat_supervisor_core
  import trhb_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_tvalid_i,
  output logic         s_tready_o,
  // op, channel, client, claim_count, tag, plate_word, has_image, zero fill
  input  logic [119:0] s_tdata_i,
  output logic         m_tvalid_o,
  input  logic         m_tready_i,
  // kind, channel_res, client_res, tag_res, plate_word_res, claimed, armed, fill
  output logic [119:0] m_tdata_o,
  output logic         m_tlast_o,
  input  logic         psel_i,
  input  logic         penable_i,
  input  logic         pwrite_i,
  input  logic [4:0]   paddr_i,
  input  logic [31:0]  pwdata_i,
  output logic [31:0]  prdata_o,
  output logic         pready_o
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_DECODE, ST_CLAIM, ST_CLOSE, ST_CLOSE_EMIT, ST_WALK, ST_FLUSH
  } seq_e;

  seq_e state_q;

  // settings
  logic [3:0]  active_q, limit_q;
  logic [15:0] hb_int_q, reply_q, retry_q, delay_q;

  // channel table
  logic [2:0]           cs_q      [NUM_CHANNELS];
  logic                 in_use_q  [NUM_CHANNELS];
  logic [7:0]           owner_q   [NUM_CHANNELS];
  logic                 alive_q   [NUM_CHANNELS];
  logic [TIME_BITS-1:0] heard_q   [NUM_CHANNELS];
  logic [15:0]          rc_q      [NUM_CHANNELS];
  logic [TIME_BITS-1:0] fire_q    [NUM_CHANNELS];
  logic [TIME_BITS-1:0] wstart_q  [NUM_CHANNELS];
  logic [3:0]           retries_q [NUM_CHANNELS];
  logic [31:0]          tag_q     [NUM_CHANNELS];
  logic [63:0]          plate_q   [NUM_CHANNELS];

  logic [TIME_BITS-1:0] now_q;
  logic [7:0]           cp_q;
  logic                 any_q;
  logic [CH_W-1:0]      idx_q;

  // captured item
  logic [2:0]  op_q, ch_q;
  logic [7:0]  cl_q, want_q;
  logic [31:0] itag_q;
  logic [63:0] iplate_q;
  logic        img_q;

  // report queue
  logic hold_v_q, out_v_q, out_last_q;
  res_t hold_q, out_q;

  logic [CNT_W-1:0]     n, k;
  logic [CH_W-1:0]      rd_idx;
  logic [2:0]           cs;
  logic [TIME_BITS-1:0] sel_time, diff;
  logic [15:0]          thr;
  logic                 gt, reached;
  logic [3:0]           ret_inc;
  logic                 ch_ok, idx_last, claim_last, emit, can_push, stall;
  res_t                 res;

  assign pready_o   = 1'b1;
  assign s_tready_o = (state_q == ST_IDLE);
  assign m_tvalid_o = out_v_q;
  assign m_tlast_o  = out_last_q;
  assign m_tdata_o  = {5'd0, out_q};

  // register read-back
  always_comb begin
    unique case (paddr_i[4:2])
      R_ACTIVE: prdata_o = {28'd0, active_q};
      R_HB_INT: prdata_o = {16'd0, hb_int_q};
      R_REPLY:  prdata_o = {16'd0, reply_q};
      R_RETRY:  prdata_o = {16'd0, retry_q};
      R_LIMIT:  prdata_o = {28'd0, limit_q};
      R_DELAY:  prdata_o = {16'd0, delay_q};
      default:  prdata_o = 32'd0;
    endcase
  end

  // present and claimed channel counts
  always_comb begin
    n = (active_q > 4'(NUM_CHANNELS)) ? CNT_W'(NUM_CHANNELS) : CNT_W'(active_q);
    k = (want_q == 8'd0 || want_q > 8'(n)) ? n : CNT_W'(want_q);
  end

  // shared subtract and compare on the selected entry
  always_comb begin
    rd_idx     = (state_q == ST_DECODE) ? ch_q[CH_W-1:0] : idx_q;
    cs         = cs_q[rd_idx];
    sel_time   = (cs == CS_ARMED) ? fire_q[rd_idx] :
                 (cs == CS_WAIT)  ? wstart_q[rd_idx] : heard_q[rd_idx];
    thr        = (cs == CS_WAIT) ? retry_q : hb_int_q;
    diff       = now_q - sel_time;
    gt         = diff > TIME_BITS'(thr);
    ret_inc    = (retries_q[rd_idx] == 4'hf) ? 4'hf : retries_q[rd_idx] + 4'd1;
    reached    = ret_inc >= limit_q;
    ch_ok      = CNT_W'(ch_q) < n;
    idx_last   = (CNT_W'(idx_q) == n - CNT_W'(1));
    claim_last = (CNT_W'(idx_q) == k - CNT_W'(1));
  end

  // report request of the current step
  always_comb begin
    emit = 1'b0;
    res  = '0;
    res.channel = rd_idx;
    res.client  = owner_q[rd_idx];
    case (state_q)
      ST_DECODE: begin
        if (op_q == OP_ARM) begin
          emit        = 1'b1;
          res.kind    = K_ARM_ACK;
          res.channel = ch_q;
          res.client  = ch_ok ? owner_q[rd_idx] : 8'd0;
          res.armed   = ch_ok && (cs == CS_IDLE);
        end else if (op_q == OP_CLAIM && k == '0) begin
          emit        = 1'b1;
          res.kind    = K_CLAIMED;
          res.channel = 3'd0;
          res.client  = cl_q;
          res.claimed = 4'(k);
        end
      end
      ST_CLAIM: begin
        if (claim_last) begin
          emit        = 1'b1;
          res.kind    = K_CLAIMED;
          res.channel = 3'd0;
          res.client  = cl_q;
          res.claimed = 4'(k);
        end
      end
      ST_CLOSE_EMIT: begin
        emit        = any_q;
        res.kind    = K_CLOSED;
        res.channel = 3'd0;
        res.client  = cp_q;
      end
      ST_WALK: begin
        if (in_use_q[rd_idx]) begin
          case (cs)
            CS_IDLE: begin
              emit     = (rc_q[rd_idx] == 16'd0) && alive_q[rd_idx] && gt;
              res.kind = K_HBEAT;
            end
            CS_ARMED: begin
              emit     = !diff[TIME_BITS-1];
              res.kind = K_FIRE;
            end
            CS_WAIT: begin
              emit     = gt;
              res.kind = reached ? K_FAILED : K_RETRY;
              res.tag  = reached ? tag_q[rd_idx] : 32'd0;
            end
            CS_RESULT: begin
              emit      = 1'b1;
              res.kind  = K_SUCCESS;
              res.tag   = tag_q[rd_idx];
              res.plate = plate_q[rd_idx];
            end
            default: emit = 1'b0;
          endcase
        end
      end
      default: emit = 1'b0;
    endcase
    can_push = !out_v_q || m_tready_i;
    stall    = emit && hold_v_q && !can_push;
  end

  // sequencer, table and report registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      active_q   <= 4'd8;
      hb_int_q   <= 16'd30000;
      reply_q    <= 16'd5000;
      retry_q    <= 16'd500;
      limit_q    <= 4'd6;
      delay_q    <= 16'd500;
      now_q      <= '0;
      cp_q       <= 8'd0;
      any_q      <= 1'b0;
      idx_q      <= '0;
      hold_v_q   <= 1'b0;
      out_v_q    <= 1'b0;
      out_last_q <= 1'b0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        cs_q[i]      <= CS_UNUSED;
        in_use_q[i]  <= 1'b0;
        owner_q[i]   <= 8'd0;
        alive_q[i]   <= 1'b0;
        heard_q[i]   <= '0;
        rc_q[i]      <= 16'd0;
        fire_q[i]    <= '0;
        wstart_q[i]  <= '0;
        retries_q[i] <= 4'd0;
        tag_q[i]     <= 32'd0;
        plate_q[i]   <= 64'd0;
      end
    end else begin
      // configuration writes
      if (psel_i && penable_i && pwrite_i) begin
        unique case (paddr_i[4:2])
          R_ACTIVE: active_q <= pwdata_i[3:0];
          R_HB_INT: hb_int_q <= pwdata_i[15:0];
          R_REPLY:  reply_q  <= pwdata_i[15:0];
          R_RETRY:  retry_q  <= pwdata_i[15:0];
          R_LIMIT:  limit_q  <= pwdata_i[3:0];
          R_DELAY:  delay_q  <= pwdata_i[15:0];
          default:  ;
        endcase
      end

      // output register
      if ((!stall && emit && hold_v_q) || (state_q == ST_FLUSH && hold_v_q && can_push)) begin
        out_v_q    <= 1'b1;
        out_q      <= hold_q;
        out_last_q <= (state_q == ST_FLUSH);
      end else if (m_tready_i) begin
        out_v_q <= 1'b0;
      end
      if (!stall && emit) begin
        hold_v_q <= 1'b1;
        hold_q   <= res;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (s_tvalid_i) begin
            op_q     <= s_tdata_i[2:0];
            ch_q     <= s_tdata_i[5:3];
            cl_q     <= s_tdata_i[13:6];
            want_q   <= s_tdata_i[21:14];
            itag_q   <= s_tdata_i[53:22];
            iplate_q <= s_tdata_i[117:54];
            img_q    <= s_tdata_i[118];
            state_q  <= ST_DECODE;
          end
        end
        ST_DECODE: begin
          idx_q   <= '0;
          any_q   <= 1'b0;
          state_q <= ST_FLUSH;
          case (op_q)
            OP_TICK: begin
              now_q <= now_q + TIME_BITS'(1);
              if (cp_q != 8'd0 && n != '0) begin
                state_q <= ST_CLOSE;
              end else begin
                cp_q <= 8'd0;
                if (n != '0) state_q <= ST_WALK;
              end
            end
            OP_CLAIM: begin
              if (k != '0) state_q <= ST_CLAIM;
            end
            OP_ARM: begin
              if (ch_ok && cs == CS_IDLE) begin
                tag_q[rd_idx]   <= itag_q;
                heard_q[rd_idx] <= now_q;
                fire_q[rd_idx]  <= now_q + TIME_BITS'(delay_q);
                rc_q[rd_idx]    <= reply_q;
                alive_q[rd_idx] <= 1'b1;
                cs_q[rd_idx]    <= CS_ARMED;
              end
            end
            OP_HB: begin
              if (ch_ok) alive_q[rd_idx] <= 1'b1;
            end
            OP_RESULT: begin
              if (ch_ok && img_q) begin
                plate_q[rd_idx] <= iplate_q;
                cs_q[rd_idx]    <= CS_RESULT;
              end
            end
            default: ;
          endcase
        end
        ST_CLAIM: begin
          owner_q[idx_q]  <= cl_q;
          alive_q[idx_q]  <= 1'b1;
          heard_q[idx_q]  <= now_q;
          rc_q[idx_q]     <= reply_q;
          cs_q[idx_q]     <= CS_IDLE;
          in_use_q[idx_q] <= 1'b1;
          idx_q           <= idx_q + CH_W'(1);
          if (claim_last) state_q <= ST_FLUSH;
        end
        ST_CLOSE: begin
          if (owner_q[idx_q] == cp_q) begin
            owner_q[idx_q]  <= 8'd0;
            in_use_q[idx_q] <= 1'b0;
            any_q           <= 1'b1;
          end
          idx_q <= idx_q + CH_W'(1);
          if (idx_last) state_q <= ST_CLOSE_EMIT;
        end
        ST_CLOSE_EMIT: begin
          if (!stall) begin
            cp_q    <= 8'd0;
            idx_q   <= '0;
            state_q <= ST_WALK;
          end
        end
        ST_WALK: begin
          if (!stall) begin
            if (in_use_q[rd_idx]) begin
              case (cs)
                CS_IDLE: begin
                  if (rc_q[rd_idx] != 16'd0) begin
                    rc_q[rd_idx] <= rc_q[rd_idx] - 16'd1;
                  end else if (!alive_q[rd_idx]) begin
                    cp_q         <= owner_q[rd_idx];
                    cs_q[rd_idx] <= CS_UNUSED;
                  end else if (gt) begin
                    heard_q[rd_idx] <= now_q;
                    rc_q[rd_idx]    <= reply_q;
                    alive_q[rd_idx] <= 1'b0;
                  end
                end
                CS_ARMED: begin
                  if (!diff[TIME_BITS-1]) begin
                    cs_q[rd_idx]      <= CS_WAIT;
                    wstart_q[rd_idx]  <= now_q;
                    retries_q[rd_idx] <= 4'd0;
                  end
                end
                CS_WAIT: begin
                  if (gt) begin
                    wstart_q[rd_idx]  <= now_q;
                    retries_q[rd_idx] <= ret_inc;
                    if (reached) begin
                      tag_q[rd_idx]   <= 32'd0;
                      plate_q[rd_idx] <= 64'd0;
                      rc_q[rd_idx]    <= reply_q;
                      cs_q[rd_idx]    <= CS_IDLE;
                    end
                  end
                end
                CS_RESULT: begin
                  tag_q[rd_idx]   <= 32'd0;
                  plate_q[rd_idx] <= 64'd0;
                  rc_q[rd_idx]    <= reply_q;
                  cs_q[rd_idx]    <= CS_IDLE;
                end
                default: ;
              endcase
            end
            idx_q <= idx_q + CH_W'(1);
            if (idx_last) state_q <= ST_FLUSH;
          end
        end
        ST_FLUSH: begin
          if (!hold_v_q) begin
            state_q <= ST_IDLE;
          end else if (can_push) begin
            hold_v_q <= 1'b0;
            state_q  <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/core/trhb_checker.sv
module trhb_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_tvalid_i,
  input logic         s_tready_o,
  input logic         m_tvalid_o,
  input logic         m_tready_i,
  input logic [119:0] m_tdata_o,
  input logic         pready_o
);

  // a stalled report holds its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && !m_tready_i |=> m_tvalid_o && $stable(m_tdata_o))
    else $error("stalled report changed");

  // the sequencer is busy right after an input transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tvalid_i && s_tready_o |=> !s_tready_o)
    else $error("input taken while busy");

  // unused report bits stay zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o |-> m_tdata_o[119:115] == 5'd0)
    else $error("report fill bits set");

  // configuration port never waits
  assert property (@(posedge clk_i) disable iff (!rst_ni) pready_o)
    else $error("pready low");

endmodule

bind trigger_retry_heartbeat_supervisor_core trhb_checker u_trhb_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .s_tvalid_i(s_tvalid_i), .s_tready_o(s_tready_o),
  .m_tvalid_o(m_tvalid_o), .m_tready_i(m_tready_i), .m_tdata_o(m_tdata_o),
  .pready_o(pready_o)
);
